// ===== hdl/bike_cadence_page_decoder_defines.svh =====
// Assertion macros for the cadence page decoder.
// Both macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef BIKE_CADENCE_PAGE_DECODER_DEFINES_SVH
`define BIKE_CADENCE_PAGE_DECODER_DEFINES_SVH

// Implication to the next cycle, quiet while reset is held.
`define BCPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after a reset cycle.
`define BCPD_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpd_pkg
// Shared types and constants of the cadence page decoder: configuration
// layout, the command passed from front to back, and divider sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpd_pkg;

    // cadence scaling: revolutions per minute from 1/1024 s ticks
    localparam int unsigned SECONDS_PER_MIN = 60;
    localparam int unsigned TICKS_PER_SEC   = 1024;
    localparam int unsigned RPM_SCALE       = SECONDS_PER_MIN * TICKS_PER_SEC;

    // page numbers, toggle bit masked off
    localparam logic [7:0] PAGE_NUM_MASK = 8'h7F;
    localparam logic [7:0] PAGE_OP_TIME  = 8'd1;
    localparam logic [7:0] PAGE_MANUF    = 8'd2;
    localparam logic [7:0] PAGE_VERSION  = 8'd3;

    // stall counter saturation
    localparam logic [7:0] UNCHANGED_MAX = 8'd255;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_STALL_LIMIT    = 2'd0;
    localparam t_cfg_index CFG_FRACTION_SCALE = 2'd1;
    localparam t_cfg_index CFG_USER_TAG       = 2'd2;

    localparam logic [7:0]  STALL_LIMIT_RST    = 8'd12;
    localparam logic [15:0] FRACTION_SCALE_RST = 16'd1000;
    localparam logic [7:0]  USER_TAG_RST       = 8'd0;

    typedef struct packed {
        logic [7:0]  stall_limit;
        logic [15:0] fraction_scale;
        logic [7:0]  user_tag;
    } t_cfg;

    // serial divider: 32-bit dividend, 16-bit divisor, two quotient bits a cycle
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned DIVISOR_W = 16;
    localparam int unsigned DIV_STEPS = DIV_W / 2;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // front to back queue
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // what the back end does with the cadence of one page
    typedef enum logic [1:0] {
        CAD_HOLD,    // no new value, show the stored one
        CAD_STALL,   // report zero cadence
        CAD_SILENT,  // compute, show, do not flag as reported
        CAD_REPORT   // compute and report
    } t_cad_kind;

    typedef struct packed {
        t_cad_kind   kind;
        logic [31:0] num;
        logic [15:0] delta;
        logic [31:0] accum;
        logic [24:0] op_time;
        logic [7:0]  man_id;
        logic [15:0] serial;
        logic [23:0] version;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hdl/bcpd_in_if.sv =====
// ----------------------------------------------------------------------------
// bcpd_in_if
// Input channel: one sensor data page per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcpd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  page_byte;
    logic [23:0] page_payload;
    logic [15:0] event_time;
    logic [15:0] rev_count;

    modport source (
        output valid, page_byte, page_payload, event_time, rev_count,
        input  ready
    );
    modport sink (
        input  valid, page_byte, page_payload, event_time, rev_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/bcpd_out_if.sv =====
// ----------------------------------------------------------------------------
// bcpd_out_if
// Result channel: one decoded result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcpd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tag_out;
    logic        cadence_valid;
    logic [31:0] cadence_rpm;
    logic [15:0] cadence_frac;
    logic [15:0] delta_time;
    logic [31:0] accumulated_revs;
    logic [24:0] operating_time;
    logic [7:0]  manufacturer_id;
    logic [15:0] serial_high;
    logic [7:0]  hw_version;
    logic [7:0]  sw_version;
    logic [7:0]  model_number;

    modport source (
        output valid, tag_out, cadence_valid, cadence_rpm, cadence_frac, delta_time,
               accumulated_revs, operating_time, manufacturer_id, serial_high,
               hw_version, sw_version, model_number,
        input  ready
    );
    modport sink (
        input  valid, tag_out, cadence_valid, cadence_rpm, cadence_frac, delta_time,
               accumulated_revs, operating_time, manufacturer_id, serial_high,
               hw_version, sw_version, model_number,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/bcpd_fifo.sv =====
// ----------------------------------------------------------------------------
// bcpd_fifo
// Short command queue between the page front end and the cadence back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bcpd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output bcpd_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);
    import bcpd_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

    // storage, written at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== hdl/bcpd_div.sv =====
// ----------------------------------------------------------------------------
// bcpd_div
// Restoring unsigned divider, 32 by 16 bits, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bcpd_pkg::DIV_W-1:0]     i_dividend,
    input  logic [bcpd_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [bcpd_pkg::DIV_W-1:0]     o_quotient,
    output logic [bcpd_pkg::DIVISOR_W-1:0] o_remainder
);
    import bcpd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_work;   // dividend bits out, quotient bits in
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_dvs;

    logic [DIVISOR_W:0]   w_try1;
    logic [DIVISOR_W:0]   w_try2;
    logic                 w_ge1;
    logic                 w_ge2;
    logic [DIVISOR_W-1:0] w_rem1;
    logic [DIVISOR_W-1:0] w_rem2;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // two compare-subtract steps per cycle
    always_comb begin
        w_try1 = {r_rem, r_work[DIV_W-1]};
        w_ge1  = (w_try1 >= {1'b0, r_dvs});
        w_rem1 = w_ge1 ? DIVISOR_W'(w_try1 - {1'b0, r_dvs}) : w_try1[DIVISOR_W-1:0];
        w_try2 = {w_rem1, r_work[DIV_W-2]};
        w_ge2  = (w_try2 >= {1'b0, r_dvs});
        w_rem2 = w_ge2 ? DIVISOR_W'(w_try2 - {1'b0, r_dvs}) : w_try2[DIVISOR_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[DIV_W-3:0], w_ge1, w_ge2};
            r_rem  <= w_rem2;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== hdl/bcpd_front.sv =====
// ----------------------------------------------------------------------------
// bcpd_front
// Page front end: page state machine, background page decode, stall
// counting and revolution bookkeeping; emits one command per page.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bcpd_in_if.sink        i_page,
    input  bcpd_pkg::t_cfg i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output bcpd_pkg::t_cmd o_cmd
);
    import bcpd_pkg::*;

    typedef enum logic [1:0] {
        PS_INIT,
        PS_STD,
        PS_EXT
    } t_page_state;

    t_page_state r_page_state, n_page_state;
    logic [7:0]  r_prev_page;
    logic [15:0] r_past_time;
    logic [15:0] r_past_revs;
    logic [7:0]  r_unchanged, n_unchanged;
    logic        r_first, n_first;
    logic [31:0] r_accum, n_accum;
    logic [24:0] r_op_time, n_op_time;
    logic [7:0]  r_man_id, n_man_id;
    logic [15:0] r_serial, n_serial;
    logic [23:0] r_version, n_version;
    logic [15:0] r_last_delta, n_last_delta;

    logic        w_accept;
    logic        w_decode;
    logic        w_same;
    logic [15:0] w_rev_diff;
    logic [15:0] w_dt;
    logic [31:0] w_num;
    t_cad_kind   w_kind;

    assign i_page.ready = i_rst_n && !i_q_full;
    assign w_accept     = i_page.valid && i_page.ready;

    // differences wrap at 16 bits
    assign w_rev_diff = i_page.rev_count - r_past_revs;
    assign w_dt       = i_page.event_time - r_past_time;
    assign w_num      = 32'(w_rev_diff) * 32'(RPM_SCALE);
    assign w_same     = (i_page.event_time == r_past_time) && (i_page.rev_count == r_past_revs);
    assign n_accum    = r_accum + 32'(w_rev_diff);

    // page state and background decode
    always_comb begin
        n_page_state = r_page_state;
        w_decode     = 1'b0;
        unique case (r_page_state)
            PS_INIT: n_page_state = PS_STD;
            PS_STD: begin
                if (r_prev_page != i_page.page_byte) begin
                    n_page_state = PS_EXT;
                    w_decode     = 1'b1;
                end
            end
            PS_EXT: w_decode = 1'b1;
            default: n_page_state = PS_INIT;
        endcase

        n_op_time = r_op_time;
        n_man_id  = r_man_id;
        n_serial  = r_serial;
        n_version = r_version;
        if (w_decode) begin
            case (i_page.page_byte & PAGE_NUM_MASK)
                PAGE_OP_TIME: n_op_time = {i_page.page_payload, 1'b0};
                PAGE_MANUF: begin
                    n_man_id = i_page.page_payload[7:0];
                    n_serial = i_page.page_payload[23:8];
                end
                PAGE_VERSION: n_version = i_page.page_payload;
                default: ;
            endcase
        end
    end

    // stall counter and cadence classification
    always_comb begin
        n_unchanged  = r_unchanged;
        n_first      = r_first;
        n_last_delta = r_last_delta;
        w_kind       = CAD_HOLD;
        if (w_same) begin
            if (r_unchanged != UNCHANGED_MAX) begin
                n_unchanged = r_unchanged + 8'd1;
            end
            if (n_unchanged > i_cfg.stall_limit) begin
                w_kind = CAD_STALL;
            end
        end else begin
            n_unchanged  = '0;
            n_last_delta = w_dt;
            if (w_dt != '0) begin
                w_kind  = r_first ? CAD_SILENT : CAD_REPORT;
                n_first = 1'b0;
            end
        end
    end

    // command to the back end carries the state after this page
    always_comb begin
        o_cmd.kind    = w_kind;
        o_cmd.num     = w_num;
        o_cmd.delta   = n_last_delta;
        o_cmd.accum   = n_accum;
        o_cmd.op_time = n_op_time;
        o_cmd.man_id  = n_man_id;
        o_cmd.serial  = n_serial;
        o_cmd.version = n_version;
    end

    assign o_push = w_accept;

    // state update on each accepted page
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_state <= PS_INIT;
            r_prev_page  <= '0;
            r_past_time  <= '0;
            r_past_revs  <= '0;
            r_unchanged  <= '0;
            r_first      <= 1'b1;
            r_accum      <= '0;
            r_op_time    <= '0;
            r_man_id     <= '0;
            r_serial     <= '0;
            r_version    <= '0;
            r_last_delta <= '0;
        end else if (w_accept) begin
            r_page_state <= n_page_state;
            r_prev_page  <= i_page.page_byte;
            r_past_time  <= i_page.event_time;
            r_past_revs  <= i_page.rev_count;
            r_unchanged  <= n_unchanged;
            r_first      <= n_first;
            r_accum      <= n_accum;
            r_op_time    <= n_op_time;
            r_man_id     <= n_man_id;
            r_serial     <= n_serial;
            r_version    <= n_version;
            r_last_delta <= n_last_delta;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bcpd_back.sv =====
// ----------------------------------------------------------------------------
// bcpd_back
// Cadence back end: runs the integer and fractional divisions on the shared
// serial divider and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bcpd_pkg::t_cfg i_cfg,
    input  bcpd_pkg::t_cmd i_cmd,
    input  logic           i_q_empty,
    output logic           o_pop,
    bcpd_out_if.source     o_result
);
    import bcpd_pkg::*;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_QUOT,
        BS_MUL,
        BS_FSTART,
        BS_FRAC,
        BS_OUT
    } t_back_state;

    typedef struct packed {
        logic [7:0]  tag_out;
        logic        cadence_valid;
        logic [31:0] cadence_rpm;
        logic [15:0] cadence_frac;
        logic [15:0] delta_time;
        logic [31:0] accumulated_revs;
        logic [24:0] operating_time;
        logic [7:0]  manufacturer_id;
        logic [15:0] serial_high;
        logic [7:0]  hw_version;
        logic [7:0]  sw_version;
        logic [7:0]  model_number;
    } t_result;

    t_back_state r_state;
    t_cmd        r_cmd;
    logic [31:0] r_prod;
    logic [31:0] r_last_int;
    logic [15:0] r_last_frac;
    logic        r_out_valid;
    t_result     r_res;

    logic                 w_compute;
    logic                 w_out_free;
    logic                 w_div_start;
    logic [DIV_W-1:0]     w_div_dividend;
    logic [DIVISOR_W-1:0] w_div_divisor;
    logic                 w_div_done;
    logic [DIV_W-1:0]     w_div_quot;
    logic [DIVISOR_W-1:0] w_div_rem;

    assign o_pop      = (r_state == BS_IDLE) && !i_q_empty;
    assign w_compute  = (i_cmd.kind == CAD_SILENT) || (i_cmd.kind == CAD_REPORT);
    assign w_out_free = !r_out_valid || o_result.ready;

    // divider launch: integer part from the queue head, fraction from the product
    assign w_div_start    = (o_pop && w_compute) || (r_state == BS_FSTART);
    assign w_div_dividend = (r_state == BS_IDLE) ? i_cmd.num : r_prod;
    assign w_div_divisor  = (r_state == BS_IDLE) ? i_cmd.delta : r_cmd.delta;

    bcpd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quot),
        .o_remainder (w_div_rem)
    );

    // sequencer, cadence store and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_last_int  <= '0;
            r_last_frac <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output beat loads in BS_OUT, drops once taken
            if ((r_state == BS_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                BS_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_state <= w_compute ? BS_QUOT : BS_OUT;
                    end
                end
                BS_QUOT: begin
                    if (w_div_done) begin
                        r_last_int <= w_div_quot;
                        r_state    <= BS_MUL;
                    end
                end
                BS_MUL: begin
                    r_prod  <= 32'(w_div_rem) * 32'(i_cfg.fraction_scale);
                    r_state <= BS_FSTART;
                end
                BS_FSTART: r_state <= BS_FRAC;
                BS_FRAC: begin
                    if (w_div_done) begin
                        r_last_frac <= w_div_quot[15:0];
                        r_state     <= BS_OUT;
                    end
                end
                BS_OUT: begin
                    if (w_out_free) begin
                        r_res.tag_out              <= i_cfg.user_tag;
                        r_res.cadence_valid        <= (r_cmd.kind == CAD_STALL) ||
                                                      (r_cmd.kind == CAD_REPORT);
                        r_res.cadence_rpm          <= (r_cmd.kind == CAD_STALL) ? '0 : r_last_int;
                        r_res.cadence_frac         <= (r_cmd.kind == CAD_STALL) ? '0 : r_last_frac;
                        r_res.delta_time           <= r_cmd.delta;
                        r_res.accumulated_revs     <= r_cmd.accum;
                        r_res.operating_time       <= r_cmd.op_time;
                        r_res.manufacturer_id      <= r_cmd.man_id;
                        r_res.serial_high          <= r_cmd.serial;
                        r_res.hw_version           <= r_cmd.version[7:0];
                        r_res.sw_version           <= r_cmd.version[15:8];
                        r_res.model_number         <= r_cmd.version[23:16];
                        r_state                    <= BS_IDLE;
                    end
                end
                default: r_state <= BS_IDLE;
            endcase
        end
    end

    // result beat
    assign o_result.valid            = r_out_valid;
    assign o_result.tag_out          = r_res.tag_out;
    assign o_result.cadence_valid    = r_res.cadence_valid;
    assign o_result.cadence_rpm      = r_res.cadence_rpm;
    assign o_result.cadence_frac     = r_res.cadence_frac;
    assign o_result.delta_time       = r_res.delta_time;
    assign o_result.accumulated_revs = r_res.accumulated_revs;
    assign o_result.operating_time   = r_res.operating_time;
    assign o_result.manufacturer_id  = r_res.manufacturer_id;
    assign o_result.serial_high      = r_res.serial_high;
    assign o_result.hw_version       = r_res.hw_version;
    assign o_result.sw_version       = r_res.sw_version;
    assign o_result.model_number     = r_res.model_number;

endmodule

`default_nettype wire

// ===== hdl/bike_cadence_page_decoder.sv =====
// ----------------------------------------------------------------------------
// bike_cadence_page_decoder
// Decodes crank cadence sensor data pages into cadence and device info.
//
// i_page takes one 8-byte data page per beat; o_result returns exactly one
// result beat per page, in order. Config writes (i_cfg_we, i_cfg_index,
// i_cfg_data) set stall limit, fraction scale and user tag; write only idle.
// A page that yields a new cadence needs two 32/16 divisions on one shared
// radix-4 divider plus a multiply before its result is valid; other pages
// skip the divider and go straight to the output register. The back end
// finishes one page before it takes the next page from the queue.
// A two-entry queue sits between the page front end and the cadence back
// end, so pages keep being accepted while the divider runs.
// Synchronous reset clears the control, queue and page tracking state and
// the config registers go to stall limit 12, fraction scale 1000, tag 0.
// If the receiver stalls, the result register holds, the back end and then
// the queue fill, and i_page ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bike_cadence_page_decoder_defines.svh"

module bike_cadence_page_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bcpd_in_if.sink                         i_page,
    bcpd_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [bcpd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bcpd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bcpd_pkg::*;

    t_cfg r_cfg;
    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stall_limit    <= STALL_LIMIT_RST;
            r_cfg.fraction_scale <= FRACTION_SCALE_RST;
            r_cfg.user_tag       <= USER_TAG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STALL_LIMIT:    r_cfg.stall_limit    <= i_cfg_data[7:0];
                CFG_FRACTION_SCALE: r_cfg.fraction_scale <= i_cfg_data;
                CFG_USER_TAG:       r_cfg.user_tag       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    bcpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_page   (i_page),
        .i_cfg    (r_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    bcpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    bcpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (w_cmd_out),
        .i_q_empty (w_q_empty),
        .o_pop     (w_pop),
        .o_result  (o_result)
    );

    // checks
    `BCPD_ASSERT_NEXT(a_push_lands, w_push, !w_q_empty, "accepted page missing from queue")
    `BCPD_ASSERT_NEXT(a_pop_frees, w_pop && !w_push, !w_q_full, "queue still full after pop")
    `BCPD_ASSERT_RESET(a_reset_clears, w_q_empty && !o_result.valid, "reset left work pending")

endmodule

`default_nettype wire

// ===== dv/bike_cadence_page_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// bike_cadence_page_decoder_tb
// Self-checking bench for the cadence page decoder. A queue of sensor pages
// is driven in bursts into the page channel; each accepted beat runs through
// a behavioral copy of the decoder, and every result beat is compared field
// by field against the oldest predicted result. Config is changed between
// rides while the block is idle, and the result side stalls on its own.
// ----------------------------------------------------------------------------
module bike_cadence_page_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcpd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_AFTER   = 500;   // results seen before the long hold
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0]  page_byte;
        logic [23:0] payload;
        logic [15:0] event_time;
        logic [15:0] rev_count;
    } t_page;

    typedef struct packed {
        logic [7:0]  tag;
        logic        cad_valid;
        logic [31:0] rpm;
        logic [15:0] frac;
        logic [15:0] delta;
        logic [31:0] revs_total;
        logic [24:0] op_time;
        logic [7:0]  man_id;
        logic [15:0] serial;
        logic [7:0]  hw_ver;
        logic [7:0]  sw_ver;
        logic [7:0]  model;
    } t_result;

    // decoder page tracking
    typedef enum logic [1:0] {
        PG_FIRST,   // very first page, skipped
        PG_SAME,    // waiting for the page byte to change
        PG_DECODE   // background pages always decoded
    } t_page_track;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  cfg_we;
    t_cfg_index            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bcpd_in_if  page_if ();
    bcpd_out_if result_if ();

    bike_cadence_page_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_page      (page_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral decoder state and config copy
    // ------------------------------------------------------------------
    logic [7:0]  cfg_stall_limit = STALL_LIMIT_RST;
    logic [15:0] cfg_frac_scale  = FRACTION_SCALE_RST;
    logic [7:0]  cfg_tag         = USER_TAG_RST;

    t_page_track pg_track       = PG_FIRST;
    logic [7:0]  prev_page      = '0;
    logic [15:0] prev_time      = '0;
    logic [15:0] prev_revs      = '0;
    logic [7:0]  still_count    = '0;
    logic        awaiting_first = 1'b1;
    logic [31:0] revs_total     = '0;
    logic [24:0] op_time_q      = '0;
    logic [7:0]  man_id_q       = '0;
    logic [15:0] serial_q       = '0;
    logic [23:0] version_q      = '0;
    logic [31:0] rpm_q          = '0;
    logic [15:0] frac_q         = '0;
    logic [15:0] delta_q        = '0;

    t_page   page_backlog[$];
    t_result awaited_results[$];
    int      error_count  = 0;
    int      results_seen = 0;
    int      cycle_count  = 0;

    // stream generator memory
    logic [15:0] gen_time = '0;
    logic [15:0] gen_revs = '0;
    logic        gen_toggle = 1'b0;
    int          gen_seq = 0;

    // Work out the result beat one sensor page produces.
    function automatic t_result decode_page(t_page p);
        t_result         r;
        logic [15:0]     rev_step;
        logic [15:0]     dt;
        logic            take_bg;
        longint unsigned num;
        longint unsigned rem;
        longint unsigned span;
        rev_step    = p.rev_count - prev_revs;
        r.cad_valid = 1'b0;
        r.rpm       = rpm_q;
        r.frac      = frac_q;

        take_bg = (pg_track == PG_DECODE) ||
                  (pg_track == PG_SAME && prev_page != p.page_byte);
        if (pg_track == PG_FIRST) begin
            pg_track = PG_SAME;
        end else if (take_bg) begin
            pg_track = PG_DECODE;
        end
        if (take_bg) begin
            case (p.page_byte & PAGE_NUM_MASK)
                PAGE_OP_TIME: op_time_q = {p.payload, 1'b0};
                PAGE_MANUF: begin
                    man_id_q = p.payload[7:0];
                    serial_q = p.payload[23:8];
                end
                PAGE_VERSION: version_q = p.payload;
                default: ;
            endcase
        end
        prev_page = p.page_byte;

        if (p.event_time == prev_time && p.rev_count == prev_revs) begin
            // stalled crank: saturating count, zero cadence past the limit
            if (still_count != UNCHANGED_MAX) still_count++;
            if (still_count > cfg_stall_limit) begin
                r.cad_valid = 1'b1;
                r.rpm       = '0;
                r.frac      = '0;
            end
        end else begin
            dt          = p.event_time - prev_time;
            still_count = '0;
            if (dt != 16'd0) begin
                span   = dt;
                num    = longint'(rev_step) * RPM_SCALE;
                rem    = num % span;
                frac_q = 16'((rem * cfg_frac_scale) / span);
                rpm_q  = 32'(num / span);
                r.cad_valid    = !awaiting_first;
                r.rpm          = rpm_q;
                r.frac         = frac_q;
                awaiting_first = 1'b0;
            end
            delta_q = dt;
        end

        revs_total = revs_total + rev_step;
        prev_revs  = p.rev_count;
        prev_time  = p.event_time;

        r.tag        = cfg_tag;
        r.delta      = delta_q;
        r.revs_total = revs_total;
        r.op_time    = op_time_q;
        r.man_id     = man_id_q;
        r.serial     = serial_q;
        r.hw_ver     = version_q[7:0];
        r.sw_ver     = version_q[15:8];
        r.model      = version_q[23:16];
        return r;
    endfunction

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Page driver: bursts of beats with random gaps
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            page_if.valid <= 1'b0;
        end else begin
            if (page_if.valid && page_if.ready) begin
                awaited_results.push_back(decode_page(page_backlog.pop_front()));
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        3:       gap_left = $urandom_range(9, 60);
                        default: gap_left = $urandom_range(1, 8);
                    endcase
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                page_if.valid <= 1'b0;
            end else if (page_backlog.size() != 0) begin
                page_if.valid        <= 1'b1;
                page_if.page_byte    <= page_backlog[0].page_byte;
                page_if.page_payload <= page_backlog[0].payload;
                page_if.event_time   <= page_backlog[0].event_time;
                page_if.rev_count    <= page_backlog[0].rev_count;
            end else begin
                page_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and ready pattern
    // ------------------------------------------------------------------
    int rx_cycle  = 0;
    int rx_mode   = 0;
    int stall_run = 0;
    int hold_cnt  = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with nothing pending, rpm %0h", $time,
                             result_if.cadence_rpm);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    cmp_field("tag_out",          want.tag,        result_if.tag_out);
                    cmp_field("cadence_valid",    want.cad_valid,  result_if.cadence_valid);
                    cmp_field("cadence_rpm",      want.rpm,        result_if.cadence_rpm);
                    cmp_field("cadence_frac",     want.frac,       result_if.cadence_frac);
                    cmp_field("delta_time",       want.delta,      result_if.delta_time);
                    cmp_field("accumulated_revs", want.revs_total,
                              result_if.accumulated_revs);
                    cmp_field("operating_time",   want.op_time,    result_if.operating_time);
                    cmp_field("manufacturer_id",  want.man_id,     result_if.manufacturer_id);
                    cmp_field("serial_high",      want.serial,     result_if.serial_high);
                    cmp_field("hw_version",       want.hw_ver,     result_if.hw_version);
                    cmp_field("sw_version",       want.sw_ver,     result_if.sw_version);
                    cmp_field("model_number",     want.model,      result_if.model_number);
                end
            end

            rx_cycle++;
            if (hold_cnt > 0) begin
                hold_cnt--;
                result_if.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                // long hold-off so the decoder backs up into the page channel
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
                result_if.ready <= 1'b0;
            end else begin
                if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0: result_if.ready <= 1'b1;
                    1: result_if.ready <= 1'($urandom_range(0, 1));
                    2: result_if.ready <= (rx_cycle % 4 != 0);
                    default: begin
                        if (stall_run > 0) begin
                            stall_run--;
                            result_if.ready <= 1'b0;
                        end else if ($urandom_range(0, 15) == 0) begin
                            stall_run = $urandom_range(1, 40);
                            result_if.ready <= 1'b0;
                        end else begin
                            result_if.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic offer_page(logic [7:0] pb, logic [23:0] pl, logic [15:0] et,
                              logic [15:0] rc);
        t_page p;
        p.page_byte  = pb;
        p.payload    = pl;
        p.event_time = et;
        p.rev_count  = rc;
        page_backlog.push_back(p);
        gen_time = et;
        gen_revs = rc;
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_STALL_LIMIT:    cfg_stall_limit = val[7:0];
            CFG_FRACTION_SCALE: cfg_frac_scale  = val;
            CFG_USER_TAG:       cfg_tag         = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [7:0] limit, logic [15:0] scale, logic [7:0] tag);
        write_reg(CFG_STALL_LIMIT, {8'h00, limit});
        write_reg(CFG_FRACTION_SCALE, scale);
        write_reg(CFG_USER_TAG, {8'h00, tag});
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every page is in and every result is out, then let it settle.
    task automatic drain();
        while (page_backlog.size() != 0 || awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A ride: mostly plausible sensor traffic, with stalls, zero-time updates,
    // wide jumps and some noise. Toggle bit flips every four pages.
    task automatic add_ride(int count, bit open_with_stall);
        int          made;
        int          kind;
        int          run;
        logic [6:0]  num;
        logic [7:0]  pb;
        logic [15:0] et;
        logic [15:0] rc;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(0, 99);
            if (open_with_stall && made == 0) kind = 10;
            run = 1;
            et  = gen_time;
            rc  = gen_revs;
            if (kind < 6) begin
                et = 16'($urandom_range(0, 16'hFFFF));
                rc = 16'($urandom_range(0, 16'hFFFF));
            end else if (kind < 18) begin
                if ($urandom_range(0, 3) == 0 || open_with_stall && made == 0)
                    run = cfg_stall_limit + $urandom_range(1, 3);
                else
                    run = $urandom_range(1, 6);
            end else if (kind < 22) begin
                rc = gen_revs + 16'($urandom_range(1, 5));
            end else if (kind < 28) begin
                et = gen_time + 16'($urandom_range(1, 16'hFFFF));
                rc = gen_revs + 16'($urandom_range(0, 16'hFFFF));
            end else begin
                et = gen_time + 16'($urandom_range(200, 3000));
                rc = gen_revs + 16'($urandom_range(0, 2));
            end
            for (int k = 0; k < run && made < count; k++) begin
                gen_seq++;
                if (gen_seq % 4 == 0) gen_toggle = ~gen_toggle;
                if ($urandom_range(0, 7) == 0) num = 7'($urandom_range(1, 3));
                else num = $urandom_range(0, 1) ? 7'd0 : 7'd4;
                pb = {gen_toggle, num};
                if ($urandom_range(0, 19) == 0) pb = 8'($urandom_range(0, 255));
                offer_page(pb, 24'($urandom_range(0, 24'hFFFFFF)), et, rc);
                made++;
            end
        end
    endtask

    initial begin
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_STALL_LIMIT;
        cfg_data               = '0;
        page_if.valid          = 1'b0;
        page_if.page_byte      = '0;
        page_if.page_payload   = '0;
        page_if.event_time     = '0;
        page_if.rev_count      = '0;
        result_if.ready        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first page skipped, unchanged page not decoded, then
        // background pages, zero dt, no revs, wraps, max cadence, fraction,
        // unknown pages, and a stall run past the reset limit.
        offer_page(8'h00, 24'hFFFFFF, 16'h0000, 16'h0000);
        offer_page(8'h00, 24'hABCDEF, 16'h0000, 16'h0000);
        offer_page(8'h81, 24'hFFFFFF, 16'h0400, 16'h0001);
        offer_page(8'h01, 24'h000000, 16'h0800, 16'h0002);
        offer_page(8'h02, 24'hFFFFFF, 16'h0800, 16'h0003);
        offer_page(8'h82, 24'h123456, 16'h0BB8, 16'h0003);
        offer_page(8'h03, 24'h0000FF, 16'hFFFF, 16'hFFFF);
        offer_page(8'h83, 24'hFFFFFF, 16'h0001, 16'h0002);
        offer_page(8'h04, 24'h5A5A5A, 16'h0002, 16'h0001);
        offer_page(8'h7F, 24'hA5A5A5, 16'h0009, 16'h0002);
        for (int k = 0; k < 13; k++)
            offer_page((k % 2 == 0) ? 8'hFF : 8'h80, 24'($urandom_range(0, 24'hFFFFFF)),
                       16'h0009, 16'h0002);
        offer_page(8'h80, 24'h000000, 16'h0100, 16'h0003);
        drain();

        // Rides under several settings, extremes included
        add_ride(250, 1'b0);
        drain();
        set_config(8'd0, 16'hFFFF, 8'hFF);
        add_ride(250, 1'b0);
        drain();
        set_config(8'd255, 16'd1, 8'h5A);
        add_ride(300, 1'b1);
        drain();
        set_config(8'd3, 16'd0, 8'hA5);
        add_ride(150, 1'b0);
        drain();
        for (int k = 0; k < 3; k++) begin
            set_config(8'($urandom_range(0, 20)), 16'($urandom_range(1, 16'hFFFF)),
                       8'($urandom_range(0, 255)));
            add_ride(150, 1'b0);
            drain();
        end

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bcpd_pkg.sv
hdl/bcpd_in_if.sv
hdl/bcpd_out_if.sv
hdl/bcpd_fifo.sv
hdl/bcpd_div.sv
hdl/bcpd_front.sv
hdl/bcpd_back.sv
hdl/bike_cadence_page_decoder.sv
dv/bike_cadence_page_decoder_tb.sv
